@@ hw/rtl/epm_pkg.sv @@
`default_nettype none

package epm_pkg;

    localparam int POOL_DEPTH = 32;
    localparam int WORD_W     = 64;
    localparam int LANE_NUM   = 4;
    localparam int ROW_NUM    = POOL_DEPTH / LANE_NUM;
    localparam int ROW_AW     = $clog2(ROW_NUM);
    localparam int LANE_AW    = $clog2(LANE_NUM);
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int QR_STAGES  = 4;

    // lanes of one row, in quarter-round roles
    localparam logic [LANE_AW-1:0] LANE_A = 2'd0;
    localparam logic [LANE_AW-1:0] LANE_B = 2'd1;
    localparam logic [LANE_AW-1:0] LANE_C = 2'd2;
    localparam logic [LANE_AW-1:0] LANE_D = 2'd3;

    localparam logic [5:0] ROT_0 = 6'd32;
    localparam logic [5:0] ROT_1 = 6'd24;
    localparam logic [5:0] ROT_2 = 6'd16;
    localparam logic [5:0] ROT_3 = 6'd63;

    localparam logic REQ_MIX  = 1'b0;
    localparam logic REQ_DRAW = 1'b1;

    typedef logic [LANE_NUM-1:0][WORD_W-1:0] t_row;

    typedef struct packed {
        logic              vld;
        logic [ROW_AW-1:0] row;
    } t_qr_tag;

    // word w lives in row {w[4], w[1:0]}, lane w[3:2]; each row is one quarter-round group
    function automatic logic [ROW_AW-1:0] word_row(input logic [IDX_W-1:0] w);
        return {w[IDX_W-1], w[LANE_AW-1:0]};
    endfunction

    function automatic logic [LANE_AW-1:0] word_lane(input logic [IDX_W-1:0] w);
        return w[IDX_W-2:LANE_AW];
    endfunction

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input logic [5:0] n);
        return (x << n) | (x >> (7'd64 - {1'b0, n}));
    endfunction

    // a += b; d ^= a; d = rotl(d)
    function automatic t_row qr_step_ad(input t_row x, input logic [5:0] rot);
        t_row y;
        y = x;
        y[LANE_A] = x[LANE_A] + x[LANE_B];
        y[LANE_D] = rotl64(x[LANE_D] ^ y[LANE_A], rot);
        return y;
    endfunction

    // c += d; b ^= c; b = rotl(b)
    function automatic t_row qr_step_cb(input t_row x, input logic [5:0] rot);
        t_row y;
        y = x;
        y[LANE_C] = x[LANE_C] + x[LANE_D];
        y[LANE_B] = rotl64(x[LANE_B] ^ y[LANE_C], rot);
        return y;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/epm_pool_mem.sv @@
`default_nettype none

module epm_pool_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [epm_pkg::ROW_AW-1:0]  i_wr_addr,
    input  wire epm_pkg::t_row               i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [epm_pkg::ROW_AW-1:0]  i_rd_addr,
    output epm_pkg::t_row                    o_rd_data
);

    epm_pkg::t_row r_mem [epm_pkg::ROW_NUM];
    epm_pkg::t_row r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/epm_qr_unit.sv @@
`default_nettype none

module epm_qr_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire epm_pkg::t_qr_tag i_tag,
    input  wire epm_pkg::t_row    i_row,
    output epm_pkg::t_qr_tag      o_tag,
    output epm_pkg::t_row         o_row
);

    epm_pkg::t_qr_tag r_tag [epm_pkg::QR_STAGES];
    epm_pkg::t_row    r_row [epm_pkg::QR_STAGES];
    epm_pkg::t_row    n_row [epm_pkg::QR_STAGES];

    // one add-xor-rotate step per stage
    always_comb begin
        n_row[0] = epm_pkg::qr_step_ad(i_row,    epm_pkg::ROT_0);
        n_row[1] = epm_pkg::qr_step_cb(r_row[0], epm_pkg::ROT_1);
        n_row[2] = epm_pkg::qr_step_ad(r_row[1], epm_pkg::ROT_2);
        n_row[3] = epm_pkg::qr_step_cb(r_row[2], epm_pkg::ROT_3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < epm_pkg::QR_STAGES; s++) begin
                r_tag[s] <= '0;
            end
        end else begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < epm_pkg::QR_STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < epm_pkg::QR_STAGES; s++) begin
            r_row[s] <= n_row[s];
        end
    end

    assign o_tag = r_tag[epm_pkg::QR_STAGES-1];
    assign o_row = r_row[epm_pkg::QR_STAGES-1];

endmodule

`default_nettype wire

@@ hw/rtl/entropy_pool_mixer_core.sv @@
`default_nettype none

// channel  | valid    | ready    | payload
// ---------+----------+----------+-----------------------------
// request  | i_valid  | o_ready  | i_req_type, i_input_word
// result   | o_valid  | i_ready  | o_random_word
//
// a new request is not taken until a transaction's row 0 is written back: the 8 pool
// rows are read one per cycle from the pool memory and each passes through the
// 4-stage quarter-round pipeline before it is written back; row 0 is written last.
// a draw result enters the output register as row 0 is written back, or the skid entry if full.
// reset clears the row valid bits at once; an unwritten row reads as zero.
// a stalled result waits in the output register, a second one in a skid entry;
// a new request is taken while a result waits, as long as the skid entry is free.

module entropy_pool_mixer_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_req_type,
    input  wire logic [epm_pkg::WORD_W-1:0]  i_input_word,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [epm_pkg::WORD_W-1:0]  o_random_word
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    localparam logic [epm_pkg::IDX_W-1:0]  W0_IDX  = '0;
    localparam logic [epm_pkg::IDX_W-1:0]  W1_IDX  = epm_pkg::IDX_W'(1);
    localparam logic [epm_pkg::IDX_W-1:0]  W16_IDX = epm_pkg::IDX_W'(epm_pkg::POOL_DEPTH / 2);
    localparam logic [epm_pkg::ROW_AW-1:0] LAST_CNT = epm_pkg::ROW_AW'(epm_pkg::ROW_NUM - 1);

    t_state                          r_state, n_state;
    logic [epm_pkg::IDX_W-1:0]       r_widx;
    logic                            r_draw;
    logic [epm_pkg::WORD_W-1:0]      r_word;
    logic                            r_issue;
    logic [epm_pkg::ROW_AW-1:0]      r_rd_cnt;
    logic [epm_pkg::ROW_NUM-1:0]     r_row_init;
    logic                            r_rd_vld;
    logic [epm_pkg::ROW_AW-1:0]      r_rd_row;
    logic                            r_rd_init;
    logic [epm_pkg::WORD_W-1:0]      r_w1, r_w16;
    logic                            r_out_vld, n_out_vld;
    logic [epm_pkg::WORD_W-1:0]      r_out_data, n_out_data;
    logic                            r_skid_vld, n_skid_vld;
    logic [epm_pkg::WORD_W-1:0]      r_skid_data, n_skid_data;

    logic                            in_fire, out_take;
    logic [epm_pkg::ROW_AW-1:0]      rd_addr;
    epm_pkg::t_row                   rd_data;
    epm_pkg::t_row                   row_in;
    epm_pkg::t_qr_tag                qr_in_tag, wb_tag;
    epm_pkg::t_row                   wb_row, wr_data;
    logic                            wb_last, res_fire;
    logic [epm_pkg::WORD_W-1:0]      res_word;

    assign o_ready  = (r_state == S_IDLE) && !r_skid_vld;
    assign in_fire  = i_valid && o_ready;
    assign out_take = r_out_vld && i_ready;

    // rows go out in the order 1..7 then 0, so word 1 is known before row 0 is written
    assign rd_addr = r_rd_cnt + epm_pkg::ROW_AW'(1);

    epm_pool_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wb_tag.vld),
        .i_wr_addr (wb_tag.row),
        .i_wr_data (wr_data),
        .i_rd_en   (r_issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // seed injection lands on the one row that holds the indexed word
    always_comb begin
        row_in = r_rd_init ? rd_data : '0;
        if (r_rd_row == epm_pkg::word_row(r_widx)) begin
            row_in[epm_pkg::word_lane(r_widx)] = row_in[epm_pkg::word_lane(r_widx)] ^ r_word;
        end
        qr_in_tag.vld = r_rd_vld;
        qr_in_tag.row = r_rd_row;
    end

    epm_qr_unit u_qr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (qr_in_tag),
        .i_row   (row_in),
        .o_tag   (wb_tag),
        .o_row   (wb_row)
    );

    assign wb_last  = wb_tag.vld && (wb_tag.row == epm_pkg::word_row(W0_IDX));
    assign res_fire = wb_last && (r_draw == epm_pkg::REQ_DRAW);
    assign res_word = wb_row[epm_pkg::word_lane(W0_IDX)] ^ r_w16;

    always_comb begin
        wr_data = wb_row;
        if (res_fire) begin
            wr_data[epm_pkg::word_lane(W0_IDX)] = wb_row[epm_pkg::word_lane(W0_IDX)] + r_w1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_RUN;
            S_RUN:   if (wb_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_skid_vld  = r_skid_vld;
        n_skid_data = r_skid_data;
        if (out_take) begin
            n_out_vld  = r_skid_vld;
            n_out_data = r_skid_data;
            n_skid_vld = 1'b0;
        end
        if (res_fire) begin
            if (!n_out_vld) begin
                n_out_vld  = 1'b1;
                n_out_data = res_word;
            end else begin
                n_skid_vld  = 1'b1;
                n_skid_data = res_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_widx     <= '0;
            r_issue    <= 1'b0;
            r_rd_cnt   <= '0;
            r_row_init <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
            r_rd_vld   <= r_issue;
            if (in_fire) begin
                r_issue  <= 1'b1;
                r_rd_cnt <= '0;
            end else if (r_issue) begin
                r_rd_cnt <= r_rd_cnt + epm_pkg::ROW_AW'(1);
                if (r_rd_cnt == LAST_CNT) begin
                    r_issue <= 1'b0;
                end
            end
            if (wb_tag.vld) begin
                r_row_init[wb_tag.row] <= 1'b1;
            end
            if (wb_last) begin
                r_widx <= r_widx + epm_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
        if (in_fire) begin
            r_draw <= i_req_type;
            r_word <= i_input_word;
        end
        if (r_issue) begin
            r_rd_row  <= rd_addr;
            r_rd_init <= r_row_init[rd_addr];
        end
        if (wb_tag.vld && wb_tag.row == epm_pkg::word_row(W1_IDX)) begin
            r_w1 <= wb_row[epm_pkg::word_lane(W1_IDX)];
        end
        if (wb_tag.vld && wb_tag.row == epm_pkg::word_row(W16_IDX)) begin
            r_w16 <= wb_row[epm_pkg::word_lane(W16_IDX)];
        end
    end

    assign o_valid       = r_out_vld;
    assign o_random_word = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready)
        else $error("request accepted while a transaction is in flight");

    a_wb_only_when_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_tag.vld |-> r_state == S_RUN)
        else $error("pool write-back outside a transaction");

    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> r_state == S_RUN)
        else $error("pool read issued while idle");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry filled with output register empty");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_fire |-> !r_skid_vld)
        else $error("draw result finished with no free output slot");

endmodule

`default_nettype wire
